### hw/rtl/dq_pkg.sv
// Package for the double-ended queue: item structs, opcodes, status codes and
// the command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FWD   = 3'd4,
    OP_READ_REV   = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entries_held;
    logic                     last_of_run;
  } out_item_t;

  // Commands from the controller, applied by the datapath at the next edge.
  typedef struct packed {
    logic    wr_front;
    logic    wr_back;
    logic    rd_front;
    logic    rd_back;
    logic    scan_start;
    logic    scan_fwd;
    logic    scan_next;
    logic    emit;
    logic    emit_mem;
    logic    emit_last;
    status_e emit_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic count_one;
    logic scan_one;
  } stat_t;

endpackage

### hw/rtl/dq_datapath.sv
// Datapath of the double-ended queue: circular entry memory, front/back
// indices, entry count, traversal pointer and the result register.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dq_pkg::cmd_t                     cmd_i,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value_i,
  output dq_pkg::stat_t                    stat_o,
  output logic                             result_valid_o,
  output dq_pkg::out_item_t                result_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = dq_pkg::CNT_W;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    return (i == IdxW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(DEPTH - 1) : i - 1'b1;
  endfunction

  logic [dq_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [dq_pkg::DATA_W-1:0] rdata_q;

  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] back_q, back_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            dir_fwd_q, dir_fwd_d;

  logic            vld_q;
  logic            sel_mem_q;
  logic [1:0]      status_q;
  logic [CntW-1:0] held_q;
  logic            last_q;

  logic [IdxW-1:0] front_m1;
  logic [IdxW-1:0] back_m1;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic            rd_en;

  assign front_m1 = idx_dec(front_q);
  assign back_m1  = idx_dec(back_q);
  assign wr_en    = cmd_i.wr_front | cmd_i.wr_back;
  assign rd_en    = cmd_i.rd_front | cmd_i.rd_back | cmd_i.scan_start | cmd_i.scan_next;
  assign wr_addr  = cmd_i.wr_front ? front_m1 : back_q;

  always_comb begin
    if (cmd_i.scan_next) begin
      rd_addr = scan_q;
    end else if (cmd_i.rd_front || (cmd_i.scan_start && cmd_i.scan_fwd)) begin
      rd_addr = front_q;
    end else begin
      rd_addr = back_m1;
    end
  end

  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    scan_d    = scan_q;
    remain_d  = remain_q;
    dir_fwd_d = dir_fwd_q;
    if (cmd_i.wr_front) begin
      front_d = front_m1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.wr_back) begin
      back_d  = idx_inc(back_q);
      count_d = count_q + 1'b1;
    end
    if (cmd_i.rd_front) begin
      front_d = idx_inc(front_q);
      count_d = count_q - 1'b1;
    end
    if (cmd_i.rd_back) begin
      back_d  = back_m1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.scan_start) begin
      dir_fwd_d = cmd_i.scan_fwd;
      scan_d    = cmd_i.scan_fwd ? idx_inc(front_q) : idx_dec(back_m1);
      remain_d  = count_q - 1'b1;
    end
    if (cmd_i.scan_next) begin
      scan_d   = dir_fwd_q ? idx_inc(scan_q) : idx_dec(scan_q);
      remain_d = remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      back_q    <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      remain_q  <= '0;
      dir_fwd_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      front_q   <= front_d;
      back_q    <= back_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      remain_q  <= remain_d;
      dir_fwd_q <= dir_fwd_d;
      vld_q     <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_value_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.emit) begin
      sel_mem_q <= cmd_i.emit_mem;
      status_q  <= cmd_i.emit_status;
      held_q    <= count_d;
      last_q    <= cmd_i.emit_last;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CntW'(DEPTH));
  assign stat_o.count_one = (count_q == CntW'(1));
  assign stat_o.scan_one  = (remain_q == CntW'(1));

  assign result_valid_o        = vld_q;
  assign result_o.result_value = sel_mem_q ? rdata_q : '0;
  assign result_o.status       = status_q;
  assign result_o.entries_held = held_q;
  assign result_o.last_of_run  = last_q;

endmodule

### hw/rtl/dq_ctrl.sv
// Controller of the double-ended queue: decodes the opcode of an accepted
// item and sequences the entry-by-entry traversal of a read.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [2:0]    opcode_i,
  input  dq_pkg::stat_t stat_i,
  output logic          busy_o,
  output dq_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.emit_status = dq_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.emit_status = dq_pkg::ST_FULL;
              end else begin
                cmd_o.wr_front = (opcode_i == dq_pkg::OP_PUSH_FRONT);
                cmd_o.wr_back  = (opcode_i == dq_pkg::OP_PUSH_BACK);
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (stat_i.empty) begin
                cmd_o.emit_status = dq_pkg::ST_EMPTY;
              end else begin
                cmd_o.rd_front = (opcode_i == dq_pkg::OP_POP_FRONT);
                cmd_o.rd_back  = (opcode_i == dq_pkg::OP_POP_BACK);
                cmd_o.emit_mem = 1'b1;
              end
            end
            dq_pkg::OP_READ_FWD, dq_pkg::OP_READ_REV: begin
              cmd_o.emit = 1'b1;
              if (stat_i.empty) begin
                cmd_o.emit_status = dq_pkg::ST_EMPTY;
                cmd_o.emit_last   = 1'b1;
              end else begin
                // The first entry is read here; the rest follow in S_SCAN.
                cmd_o.scan_start = 1'b1;
                cmd_o.scan_fwd   = (opcode_i == dq_pkg::OP_READ_FWD);
                cmd_o.emit_mem   = 1'b1;
                cmd_o.emit_last  = stat_i.count_one;
                if (!stat_i.count_one) begin
                  state_d = S_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_next = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_mem  = 1'b1;
        cmd_o.emit_last = stat_i.scan_one;
        if (stat_i.scan_one) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == S_SCAN);

endmodule

### hw/rtl/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit values in a circular store of
// DEPTH entries. An item is taken when start is high and busy is low. Push and
// pop take one cycle each: the result strobe rises in the cycle after the item
// is taken, and a new item may be taken in that same cycle. A read forward or
// reverse takes one cycle per entry held (one cycle for an empty queue),
// paced by the single read port of the entry memory; busy stays high until
// the last read is issued. Results cannot be held off by the receiver.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
`timescale 1ns / 1ps

module double_ended_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dq_pkg::in_item_t  item_i,
  output logic              result_valid_o,
  output dq_pkg::out_item_t result_o
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .push_value_i   (item_i.push_value),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  logic op_known;
  assign op_known = (item_i.opcode == dq_pkg::OP_PUSH_FRONT) ||
                    (item_i.opcode == dq_pkg::OP_PUSH_BACK)  ||
                    (item_i.opcode == dq_pkg::OP_POP_FRONT)  ||
                    (item_i.opcode == dq_pkg::OP_POP_BACK)   ||
                    (item_i.opcode == dq_pkg::OP_READ_FWD)   ||
                    (item_i.opcode == dq_pkg::OP_READ_REV);

  // Every accepted item with a known opcode produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_known) |=> result_valid_o)
    else $error("no result after an accepted item");

  // While a traversal runs, one entry comes out every cycle.
  a_scan_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_valid_o && result_o.status == dq_pkg::ST_OK))
    else $error("traversal result missing");

  // A dropped push only happens with the store full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == dq_pkg::ST_FULL) |->
      (result_o.entries_held == dq_pkg::CNT_W'(DEPTH)))
    else $error("full status with store not full");

  // The count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.entries_held <= dq_pkg::CNT_W'(DEPTH)))
    else $error("entry count beyond depth");

endmodule
